// ----- rtl/core/tbr_pkg.sv -----
// Shared types, widths and constants for the triangle barycentric rasterizer.
// Used by the controller, the datapath and the top level; no dependencies.
package tbr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 4;
  localparam int WEIGHT_BITS = 16;
  localparam int PIXEL_BITS  = 12;

  localparam int OPB_W  = COORD_BITS + 1;
  localparam int CTR_W  = PIXEL_BITS + FRAC_BITS + 1;
  localparam int XA_W   = (CTR_W + 1 > COORD_BITS + 1) ? CTR_W + 1 : COORD_BITS + 1;
  localparam int OPA_W  = XA_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int EDGE_W = PROD_W + 1;
  localparam int MAG_W  = EDGE_W + 1;
  localparam int REM_W  = MAG_W + 1;
  localparam int DIVCNT_W = $clog2(WEIGHT_BITS);

  localparam int IN_RAW_W    = 6 * COORD_BITS + 2 * PIXEL_BITS;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = 3 * WEIGHT_BITS + 2 * PIXEL_BITS + 2;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV_A,
    ST_DIV_B,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                accept;
    logic                mul_en;
    logic [1:0]          step;
    logic                check_en;
    logic                div_en;
    logic                div_sel_b;
    logic                div_last;
    logic                finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode_pixel;
    logic hit;
    logic out_busy;
  } ctrl_sts_t;

  typedef struct packed {
    logic                   degenerate;
    logic [PIXEL_BITS-1:0]  out_y;
    logic [PIXEL_BITS-1:0]  out_x;
    logic [WEIGHT_BITS-1:0] weight_c;
    logic [WEIGHT_BITS-1:0] weight_b;
    logic [WEIGHT_BITS-1:0] weight_a;
    logic                   inside_res;
  } result_t;

endpackage

// ----- rtl/core/tbr_ctrl.sv -----
// Sequencing state machine for the rasterizer: multiply steps, checks, division.
// Depends on tbr_pkg; drives the command struct of tbr_datapath.
module tbr_ctrl
  import tbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t              state_r, state_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [DIVCNT_W-1:0] cnt_r, cnt_nxt;
  logic                cnt_last;

  assign cnt_last = (cnt_r == DIVCNT_W'(WEIGHT_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.step  = step_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          step_nxt   = '0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        step_nxt   = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check_en = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = sts.mode_pixel ? ST_DIV_A : ST_FINISH;
      end
      ST_DIV_A: begin
        if (!sts.hit) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_en   = 1'b1;
          cmd.div_last = cnt_last;
          cnt_nxt      = cnt_r + DIVCNT_W'(1);
          if (cnt_last) begin
            cnt_nxt   = '0;
            state_nxt = ST_DIV_B;
          end
        end
      end
      ST_DIV_B: begin
        cmd.div_en    = 1'b1;
        cmd.div_sel_b = 1'b1;
        cmd.div_last  = cnt_last;
        cnt_nxt       = cnt_r + DIVCNT_W'(1);
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/tbr_datapath.sv -----
// Datapath of the rasterizer: vertex store, shared multiplier, edge and area
// registers, shared restoring divider and output register. Depends on tbr_pkg.
module tbr_datapath
  import tbr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output ctrl_sts_t               sts,
  input  logic                    in_command,
  input  logic [IN_TDATA_W-1:0]   in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output result_t                 out_res
);

  logic signed [COORD_BITS-1:0] vert_r [6];
  logic [PIXEL_BITS-1:0]        px_r, py_r;
  logic                         mode_r;
  logic signed [PROD_W-1:0]     acc_r;
  logic signed [EDGE_W-1:0]     s1_r, s2_r, ea_r, eb_r;
  logic                         zero_r;
  logic                         inside_r;
  logic [MAG_W-1:0]             nb_r;
  logic [REM_W-1:0]             rem_r;
  logic [WEIGHT_BITS-1:0]       quo_r, wa_r;
  logic                         out_valid_r;
  result_t                      out_res_r;

  logic signed [OPB_W-1:0] d_ab_x, d_ab_y, d_cb_x, d_cb_y, d_bc_x, d_bc_y, d_ac_x, d_ac_y;
  logic [CTR_W-1:0]        xc, yc;
  logic signed [OPA_W-1:0] xs, ys, opa;
  logic signed [OPB_W-1:0] opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [EDGE_W-1:0] term;
  logic [MAG_W-1:0]        ma, mb, na, nb, den;
  logic [MAG_W:0]          nsum;
  logic                    pa, pb, pc;
  logic [REM_W-1:0]        rem2;
  logic                    ge;
  logic [WEIGHT_BITS-1:0]  quo_nxt;
  logic [WEIGHT_BITS:0]    wc_full;
  logic [WEIGHT_BITS-1:0]  wc;
  result_t                 res_nxt;

  assign d_ab_x = OPB_W'(vert_r[0]) - OPB_W'(vert_r[2]);
  assign d_ab_y = OPB_W'(vert_r[1]) - OPB_W'(vert_r[3]);
  assign d_cb_x = OPB_W'(vert_r[4]) - OPB_W'(vert_r[2]);
  assign d_cb_y = OPB_W'(vert_r[5]) - OPB_W'(vert_r[3]);
  assign d_bc_x = OPB_W'(vert_r[2]) - OPB_W'(vert_r[4]);
  assign d_bc_y = OPB_W'(vert_r[3]) - OPB_W'(vert_r[5]);
  assign d_ac_x = OPB_W'(vert_r[0]) - OPB_W'(vert_r[4]);
  assign d_ac_y = OPB_W'(vert_r[1]) - OPB_W'(vert_r[5]);

  assign xc = CTR_W'({px_r, 1'b1}) << FRAC_BITS;
  assign yc = CTR_W'({py_r, 1'b1}) << FRAC_BITS;
  assign xs = OPA_W'(signed'({1'b0, xc}));
  assign ys = OPA_W'(signed'({1'b0, yc}));

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.step)
      2'd0: begin
        opa = (mode_r == CMD_PIXEL) ? xs - (OPA_W'(vert_r[2]) <<< 1) : OPA_W'(d_ab_x);
        opb = d_cb_y;
      end
      2'd1: begin
        opa = (mode_r == CMD_PIXEL) ? ys - (OPA_W'(vert_r[3]) <<< 1) : OPA_W'(d_ab_y);
        opb = d_cb_x;
      end
      2'd2: begin
        opa = (mode_r == CMD_PIXEL) ? xs - (OPA_W'(vert_r[4]) <<< 1) : OPA_W'(d_bc_x);
        opb = d_ac_y;
      end
      2'd3: begin
        opa = (mode_r == CMD_PIXEL) ? ys - (OPA_W'(vert_r[5]) <<< 1) : OPA_W'(d_bc_y);
        opb = d_ac_x;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = opa * opb;
  assign term = EDGE_W'(prod) - EDGE_W'(acc_r);

  assign ma = s1_r[EDGE_W-1] ? MAG_W'(-s1_r) << 1 : MAG_W'(s1_r) << 1;
  assign mb = s2_r[EDGE_W-1] ? MAG_W'(-s2_r) << 1 : MAG_W'(s2_r) << 1;
  assign na = ea_r[EDGE_W-1] ? MAG_W'(-ea_r) : MAG_W'(ea_r);
  assign nb = eb_r[EDGE_W-1] ? MAG_W'(-eb_r) : MAG_W'(eb_r);
  assign nsum = (MAG_W + 1)'(na) + (MAG_W + 1)'(nb);

  assign pa = (ea_r != '0) && (ea_r[EDGE_W-1] == s1_r[EDGE_W-1]);
  assign pb = (eb_r != '0) && (eb_r[EDGE_W-1] == s2_r[EDGE_W-1]);
  assign pc = nsum < (MAG_W + 1)'(ma);

  assign den     = cmd.div_sel_b ? mb : ma;
  assign rem2    = rem_r << 1;
  assign ge      = rem2 >= REM_W'(den);
  assign quo_nxt = {quo_r[WEIGHT_BITS-2:0], ge};

  assign wc_full = {1'b1, {WEIGHT_BITS{1'b0}}} - {1'b0, wa_r} - {1'b0, quo_r};
  assign wc      = wc_full[WEIGHT_BITS] ? {WEIGHT_BITS{1'b1}} : wc_full[WEIGHT_BITS-1:0];

  always_comb begin
    res_nxt            = '0;
    res_nxt.degenerate = zero_r;
    if (mode_r == CMD_PIXEL) begin
      res_nxt.out_x = px_r;
      res_nxt.out_y = py_r;
      if (inside_r) begin
        res_nxt.inside_res = 1'b1;
        res_nxt.weight_a   = wa_r;
        res_nxt.weight_b   = quo_r;
        res_nxt.weight_c   = wc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        vert_r[i] <= '0;
      end
      s1_r        <= '0;
      s2_r        <= '0;
      zero_r      <= 1'b1;
      mode_r      <= CMD_LOAD;
      inside_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        mode_r <= in_command;
        if (in_command == CMD_LOAD) begin
          for (int i = 0; i < 6; i++) begin
            vert_r[i] <= in_data[i*COORD_BITS +: COORD_BITS];
          end
        end else begin
          px_r <= in_data[6*COORD_BITS +: PIXEL_BITS];
          py_r <= in_data[6*COORD_BITS + PIXEL_BITS +: PIXEL_BITS];
        end
      end
      if (cmd.mul_en) begin
        if (!cmd.step[0]) begin
          acc_r <= prod;
        end else if (mode_r == CMD_LOAD) begin
          if (!cmd.step[1]) begin
            s1_r <= term;
          end else begin
            s2_r <= term;
          end
        end else begin
          if (!cmd.step[1]) begin
            ea_r <= term;
          end else begin
            eb_r <= term;
          end
        end
      end
      if (cmd.check_en) begin
        if (mode_r == CMD_LOAD) begin
          zero_r <= (s1_r == '0) || (s2_r == '0);
        end else begin
          inside_r <= !zero_r && pa && pb && pc;
          nb_r     <= nb;
          rem_r    <= REM_W'(na);
          quo_r    <= '0;
        end
      end
      if (cmd.div_en) begin
        if (cmd.div_last && !cmd.div_sel_b) begin
          wa_r  <= quo_nxt;
          rem_r <= REM_W'(nb_r);
          quo_r <= '0;
        end else begin
          rem_r <= ge ? rem2 - REM_W'(den) : rem2;
          quo_r <= quo_nxt;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_res_r <= res_nxt;
    end
  end

  assign sts.mode_pixel = (mode_r == CMD_PIXEL);
  assign sts.hit        = inside_r;
  assign sts.out_busy   = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_res        = out_res_r;

endmodule

// ----- rtl/core/triangle_barycentric_rasterizer_unit.sv -----
// Triangle rasterizer top level: a load item passes the multiply and check states,
// a pixel item then the division states if it is inside; the next item is taken
// the cycle after the result is registered. Inside pixels are set by two 16-step
// divisions on one shared restoring divider. Synchronous active-low reset clears
// the vertices and area terms and marks the triangle degenerate.
// Instantiates tbr_ctrl and tbr_datapath; depends on tbr_pkg.
module triangle_barycentric_rasterizer_unit
  import tbr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, pixel_x, pixel_y
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // inside_res, weight_a, weight_b, weight_c, out_x, out_y, degenerate
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  result_t   res;

  tbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_command (in_tuser),
    .in_data    (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = OUT_TDATA_W'(res);

endmodule

// ----- dv/tb_triangle_barycentric_rasterizer_unit.sv -----
// Testbench for the triangle barycentric rasterizer: drives load and pixel transfers
// with random bursts and output stalls, predicts every result and checks it field by field.
// Depends on tbr_pkg and triangle_barycentric_rasterizer_unit.
`timescale 1ns / 1ps

module tb_triangle_barycentric_rasterizer_unit;
  import tbr_pkg::*;

  class raster_scoreboard;
    longint vtx[6];
    longint area1, area2;
    bit flat;
    result_t pending[$];
    int errors;

    function new();
      foreach (vtx[i]) vtx[i] = 0;
      area1 = 0;
      area2 = 0;
      flat = 1;
      errors = 0;
    endfunction

    function longint unsigned weight_div(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = 0;
      r = num;
      for (int i = 0; i < WEIGHT_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      return q;
    endfunction

    function longint unsigned absval(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void note_input(logic cmd, logic [IN_TDATA_W-1:0] d);
      result_t r;
      longint ax, ay, bx, by, cx, cy, px2, py2, ea, eb, da, db;
      longint unsigned na, nb, ma, mb, wa, wb, wc, full;
      bit pa, pb, pc;
      r = '0;
      if (cmd == CMD_LOAD) begin
        for (int k = 0; k < 6; k++)
          vtx[k] = longint'($signed(d[k*COORD_BITS +: COORD_BITS]));
        ax = vtx[0]; ay = vtx[1]; bx = vtx[2]; by = vtx[3]; cx = vtx[4]; cy = vtx[5];
        area1 = -(ax - bx) * (cy - by) + (ay - by) * (cx - bx);
        area2 = -(bx - cx) * (ay - cy) + (by - cy) * (ax - cx);
        flat = (area1 == 0) || (area2 == 0);
        r.degenerate = flat;
      end else begin
        r.out_x = d[6*COORD_BITS +: PIXEL_BITS];
        r.out_y = d[6*COORD_BITS+PIXEL_BITS +: PIXEL_BITS];
        r.degenerate = flat;
        if (!flat) begin
          ax = 2*vtx[0]; ay = 2*vtx[1]; bx = 2*vtx[2];
          by = 2*vtx[3]; cx = 2*vtx[4]; cy = 2*vtx[5];
          px2 = (2*longint'(r.out_x) + 1) <<< FRAC_BITS;
          py2 = (2*longint'(r.out_y) + 1) <<< FRAC_BITS;
          ea = -(px2 - bx) * ((cy - by) / 2) + (py2 - by) * ((cx - bx) / 2);
          eb = -(px2 - cx) * ((ay - cy) / 2) + (py2 - cy) * ((ax - cx) / 2);
          da = 2*area1;
          db = 2*area2;
          pa = (ea != 0) && ((ea > 0) == (da > 0));
          pb = (eb != 0) && ((eb > 0) == (db > 0));
          if (pa && pb) begin
            na = absval(ea); nb = absval(eb); ma = absval(da); mb = absval(db);
            full = 64'd1 << WEIGHT_BITS;
            if (ma == mb) pc = (na + nb) < ma;
            else pc = (na < ma) && (nb < mb) &&
                      (weight_div(na, ma) + weight_div(nb, mb) < full - 1);
            if (pc) begin
              wa = weight_div(na, ma);
              wb = weight_div(nb, mb);
              wc = full - wa - wb;
              if (wc > full - 1) wc = full - 1;
              r.inside_res = 1'b1;
              r.weight_a = WEIGHT_BITS'(wa);
              r.weight_b = WEIGHT_BITS'(wb);
              r.weight_c = WEIGHT_BITS'(wc);
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      result_t got, exp;
      got = d[OUT_RAW_W-1:0];
      if (pending.size() == 0) begin
        mismatch("unexpected result", 0, got);
        return;
      end
      exp = pending.pop_front();
      if (got.inside_res !== exp.inside_res) mismatch("inside_res", exp.inside_res, got.inside_res);
      if (got.weight_a !== exp.weight_a) mismatch("weight_a", exp.weight_a, got.weight_a);
      if (got.weight_b !== exp.weight_b) mismatch("weight_b", exp.weight_b, got.weight_b);
      if (got.weight_c !== exp.weight_c) mismatch("weight_c", exp.weight_c, got.weight_c);
      if (got.out_x !== exp.out_x) mismatch("out_x", exp.out_x, got.out_x);
      if (got.out_y !== exp.out_y) mismatch("out_y", exp.out_y, got.out_y);
      if (got.degenerate !== exp.degenerate) mismatch("degenerate", exp.degenerate, got.degenerate);
    endfunction

    function void mismatch(string what, logic [127:0] exp, logic [127:0] got);
      $display("mismatch %s: expected %0h got %0h at %0t", what, exp, got, $time);
      errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic stall_on;
  raster_scoreboard sb;

  triangle_barycentric_rasterizer_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [IN_TDATA_W-1:0] d);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(cmd, d);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_load(logic [15:0] v0, logic [15:0] v1,
      logic [15:0] v2, logic [15:0] v3, logic [15:0] v4, logic [15:0] v5);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[95:0] = {v5, v4, v3, v2, v1, v0};
    d[IN_RAW_W-1:96] = (IN_RAW_W - 96)'($urandom);
    return d;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_pixel(logic [11:0] px, logic [11:0] py);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[95:0] = {$urandom, $urandom, $urandom};
    d[6*COORD_BITS +: PIXEL_BITS] = px;
    d[6*COORD_BITS+PIXEL_BITS +: PIXEL_BITS] = py;
    return d;
  endfunction

  function automatic logic [15:0] rand_coord(int span);
    return 16'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  // Receiver stalls in runs of random length, with some long quiet stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_on <= 1'b0;
    end else begin
      if ($urandom_range(0, 15) == 0) stall_on <= ~stall_on;
      out_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  initial begin
    int waited;
    logic [11:0] bx, by;
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_PIXEL, pack_pixel(12'd5, 12'd5));
    send_item(CMD_LOAD, pack_load(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(CMD_PIXEL, pack_pixel(12'd0, 12'd0));
    send_item(CMD_LOAD, pack_load(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
    send_item(CMD_PIXEL, pack_pixel(12'd0, 12'd0));
    send_item(CMD_PIXEL, pack_pixel(12'hfff, 12'hfff));
    send_item(CMD_PIXEL, pack_pixel(12'd100, 12'd200));
    send_item(CMD_LOAD, pack_load(16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h0400));
    send_item(CMD_PIXEL, pack_pixel(12'd10, 12'd10));
    send_item(CMD_PIXEL, pack_pixel(12'd63, 12'd0));
    send_item(CMD_PIXEL, pack_pixel(12'd0, 12'd0));
    send_item(CMD_LOAD, pack_load(16'h0008, 16'h0008, 16'h0018, 16'h0008, 16'h0008, 16'h0018));
    send_item(CMD_PIXEL, pack_pixel(12'd0, 12'd0));
    send_item(CMD_LOAD, pack_load(16'h0000, 16'h0000, 16'h0010, 16'h0010, 16'h0020, 16'h0020));
    send_item(CMD_PIXEL, pack_pixel(12'd0, 12'd0));
    send_item(CMD_LOAD, pack_load(16'h7fff, 16'h7fff, 16'h0000, 16'h7fff, 16'h7fff, 16'h0000));
    send_item(CMD_PIXEL, pack_pixel(12'd2000, 12'd2047));
    send_item(CMD_PIXEL, pack_pixel(12'd4000, 12'd4000));
    send_item(CMD_LOAD, pack_load(16'h0000, 16'h0000, 16'hfc00, 16'h0000, 16'h0000, 16'h0400));
    send_item(CMD_PIXEL, pack_pixel(12'd0, 12'd10));

    for (int n = 0; n < 1250;) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(CMD_LOAD, pack_load(16'($urandom), 16'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom), 16'($urandom)));
        n++;
      end else begin
        bx = 12'($urandom_range(0, 4000));
        by = 12'($urandom_range(0, 4000));
        if ($urandom_range(0, 1)) begin
          send_item(CMD_LOAD, pack_load(
            16'(bx*16) + rand_coord(300), 16'(by*16) + rand_coord(300),
            16'(bx*16) + rand_coord(300), 16'(by*16) + rand_coord(300),
            16'(bx*16) + rand_coord(300), 16'(by*16) + rand_coord(300)));
        end else begin
          send_item(CMD_LOAD, pack_load(
            16'(bx*16), 16'(by*16), 16'(bx*16) + 16'd240, 16'(by*16),
            16'(bx*16), 16'(by*16) + 16'd240));
        end
        n++;
        idle_gap();
        for (int p = $urandom_range(1, 10); p > 0; p--) begin
          send_item(CMD_PIXEL, pack_pixel(12'(bx + $urandom_range(0, 20) - 5),
                                          12'(by + $urandom_range(0, 20) - 5)));
          n++;
          idle_gap();
        end
      end
      idle_gap();
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tbr_pkg.sv
rtl/core/tbr_ctrl.sv
rtl/core/tbr_datapath.sv
rtl/core/triangle_barycentric_rasterizer_unit.sv
dv/tb_triangle_barycentric_rasterizer_unit.sv
